### design/sed_pkg.sv
// ----------------------------------------------------------------------------
// sed_pkg
// Types and constants shared by the slope event detector modules.
// ----------------------------------------------------------------------------
package sed_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_SAMPLE_INTERVAL = 3'd0,
    REG_MIN_LENGTH      = 3'd1,
    REG_MAX_LENGTH      = 3'd2,
    REG_RISE_LEVEL      = 3'd3,
    REG_OVERLOAD_LEVEL  = 3'd4,
    REG_FALL_LEVEL      = 3'd5,
    REG_HOLDOFF_TIME    = 3'd6
  } cfg_index_t;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned SLOPE_W  = 17;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned COUNT_W  = 32;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned OUT_W    = 56;

  // Reset values of the configuration registers
  localparam logic [CFG_W-1:0] SAMPLE_INTERVAL_RST = 16'd10;
  localparam logic [CFG_W-1:0] MIN_LENGTH_RST      = 16'd0;
  localparam logic [CFG_W-1:0] MAX_LENGTH_RST      = 16'hFFFF;
  localparam logic [CFG_W-1:0] RISE_LEVEL_RST      = 16'sd100;
  localparam logic [CFG_W-1:0] OVERLOAD_LEVEL_RST  = 16'h7FFF;
  localparam logic [CFG_W-1:0] FALL_LEVEL_RST      = 16'hFF9C;
  localparam logic [CFG_W-1:0] HOLDOFF_TIME_RST    = 16'd0;

  typedef struct packed {
    logic [CFG_W-1:0] sample_interval;
    logic [CFG_W-1:0] min_length;
    logic [CFG_W-1:0] max_length;
    logic [CFG_W-1:0] rise_level;      // two's complement
    logic [CFG_W-1:0] overload_level;  // two's complement
    logic [CFG_W-1:0] fall_level;      // two's complement
    logic [CFG_W-1:0] holdoff_time;
  } cfg_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] last_sample;
    logic [TIME_W-1:0]   time_now;
    logic [TIME_W-1:0]   holdoff_until;
    logic [TIME_W-1:0]   event_length;
    logic                armed_flag;
    logic [COUNT_W-1:0]  valid_count;
  } state_t;

  typedef struct packed {
    logic [COUNT_W-1:0] event_total;
    logic               armed;
    logic               blanked;
    logic               overloaded;
    logic               rejected;
    logic               detected;
    logic [SLOPE_W-1:0] slope;
  } result_t;

endpackage

### design/sed_step.sv
// ----------------------------------------------------------------------------
// sed_step
// Next-state and result logic for one sample: slope, hold-off test,
// overload abort, arm/end detection and duration window check.
// ----------------------------------------------------------------------------
module sed_step (
  input  sed_pkg::cfg_t                      cfg,
  input  sed_pkg::state_t                    st,
  input  logic [sed_pkg::SAMPLE_W-1:0]       sample,
  output sed_pkg::state_t                    st_next,
  output sed_pkg::result_t                   res
);
  import sed_pkg::*;

  logic signed [SLOPE_W-1:0] slope;
  logic signed [SLOPE_W-1:0] rise_ext;
  logic signed [SLOPE_W-1:0] over_ext;
  logic signed [SLOPE_W-1:0] fall_ext;
  logic [TIME_W-1:0]         time_next;
  logic [TIME_W-1:0]         len_acc;
  logic                      in_holdoff;
  logic                      in_window;

  // Slope and threshold operands, all 17-bit signed
  assign slope    = $signed({1'b0, sample}) - $signed({1'b0, st.last_sample});
  assign rise_ext = $signed({cfg.rise_level[CFG_W-1], cfg.rise_level});
  assign over_ext = $signed({cfg.overload_level[CFG_W-1], cfg.overload_level});
  assign fall_ext = $signed({cfg.fall_level[CFG_W-1], cfg.fall_level});

  // Time advance and hold-off window (plain unsigned compare, wraps)
  assign time_next  = st.time_now + {{(TIME_W-CFG_W){1'b0}}, cfg.sample_interval};
  assign in_holdoff = time_next < st.holdoff_until;

  // Event duration including this sample
  assign len_acc   = st.event_length + {{(TIME_W-CFG_W){1'b0}}, cfg.sample_interval};
  assign in_window = (len_acc >= {{(TIME_W-CFG_W){1'b0}}, cfg.min_length}) &&
                     (len_acc <= {{(TIME_W-CFG_W){1'b0}}, cfg.max_length});

  always_comb begin
    st_next             = st;
    st_next.last_sample = sample;
    st_next.time_now    = time_next;
    res                 = '0;
    res.slope           = slope;

    priority if (in_holdoff) begin
      res.blanked = 1'b1;
    end else if (slope >= over_ext) begin
      res.overloaded        = 1'b1;
      st_next.armed_flag    = 1'b0;
      st_next.event_length  = '0;
      st_next.holdoff_until = time_next + {{(TIME_W-CFG_W){1'b0}}, cfg.holdoff_time};
    end else if (st.armed_flag && (slope <= fall_ext)) begin
      // Armed event ends here
      if (in_window) begin
        st_next.valid_count = st.valid_count + {{(COUNT_W-1){1'b0}}, 1'b1};
        res.detected        = 1'b1;
      end else begin
        res.rejected = 1'b1;
      end
      st_next.armed_flag    = 1'b0;
      st_next.event_length  = '0;
      st_next.holdoff_until = time_next + {{(TIME_W-CFG_W){1'b0}}, cfg.holdoff_time};
    end else if (st.armed_flag || (slope >= rise_ext)) begin
      // Arming, or still in progress: duration grows
      st_next.armed_flag   = 1'b1;
      st_next.event_length = len_acc;
    end else begin
      // Idle and below the rise level: only sample and time move on
    end

    res.armed       = st_next.armed_flag;
    res.event_total = st_next.valid_count;
  end

endmodule

### design/slope_event_detector.sv
// ----------------------------------------------------------------------------
// slope_event_detector
// Derivative threshold pulse detector with hold-off, streaming top level.
// ----------------------------------------------------------------------------
// Takes one 16-bit sample per clock and returns one result per sample. The
// sample lands in an input register, the step logic (one 17-bit subtract, the
// 32-bit time and duration adds and their compares) runs in a single pass,
// and the result and new state are registered together as the result register
// loads. The sustained rate is one sample per cycle; the input side keeps
// taking samples while a result waits, and stalls only when both the input
// and result registers are full and the result is not taken. Configuration
// writes are accepted every cycle and take effect on the following samples.
module slope_event_detector (
  input  logic                            clk,
  input  logic                            rst,
  // Sample stream in
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [15:0]                     s_tdata,   // [15:0] sample
  // Result stream out
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [sed_pkg::OUT_W-1:0]       m_tdata,   // [16:0] slope, [17] detected,
                                                     // [18] rejected, [19] overloaded,
                                                     // [20] blanked, [21] armed,
                                                     // [53:22] event_total, [55:54] zero
  // Configuration writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [2:0]                      cfg_index,
  input  logic [sed_pkg::CFG_W-1:0]       cfg_data
);
  import sed_pkg::*;

  cfg_t                cfg;
  state_t              st;
  state_t              st_next;
  result_t             res;
  result_t             res_q;
  logic                in_valid;
  logic [SAMPLE_W-1:0] in_sample;
  logic                out_valid;
  logic                out_load;
  logic                s_xfer;

  // Handshake: result register loads from a full input register whenever it is free or being drained
  assign out_load  = in_valid && (!out_valid || m_tready);
  assign s_tready  = !in_valid || out_load;
  assign s_xfer    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  assign m_tvalid  = out_valid;
  assign m_tdata   = {{(OUT_W-$bits(result_t)){1'b0}}, res_q};

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sample_interval <= SAMPLE_INTERVAL_RST;
      cfg.min_length      <= MIN_LENGTH_RST;
      cfg.max_length      <= MAX_LENGTH_RST;
      cfg.rise_level      <= RISE_LEVEL_RST;
      cfg.overload_level  <= OVERLOAD_LEVEL_RST;
      cfg.fall_level      <= FALL_LEVEL_RST;
      cfg.holdoff_time    <= HOLDOFF_TIME_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SAMPLE_INTERVAL: cfg.sample_interval <= cfg_data;
        REG_MIN_LENGTH:      cfg.min_length      <= cfg_data;
        REG_MAX_LENGTH:      cfg.max_length      <= cfg_data;
        REG_RISE_LEVEL:      cfg.rise_level      <= cfg_data;
        REG_OVERLOAD_LEVEL:  cfg.overload_level  <= cfg_data;
        REG_FALL_LEVEL:      cfg.fall_level      <= cfg_data;
        REG_HOLDOFF_TIME:    cfg.holdoff_time    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_xfer) begin
      in_valid <= 1'b1;
    end else if (out_load) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_xfer) begin
      in_sample <= s_tdata;
    end
  end

  // Step logic
  sed_step u_step (
    .cfg     (cfg),
    .st      (st),
    .sample  (in_sample),
    .st_next (st_next),
    .res     (res)
  );

  // Detector state, advanced as each result is registered
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (out_load) begin
      st <= st_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res_q <= res;
    end
  end

  // Checks
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> s_tready)
    else $error("input stalled with an empty result register");

  a_one_outcome: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(res_q.detected && res_q.rejected))
    else $error("event both detected and rejected");

  a_abort_disarms: assert property (@(posedge clk) disable iff (rst)
    out_valid && (res_q.overloaded || res_q.detected || res_q.rejected) |-> !res_q.armed)
    else $error("detector still armed after event end or abort");

  a_blank_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && res_q.blanked |->
      !(res_q.detected || res_q.rejected || res_q.overloaded))
    else $error("blanked sample produced an event outcome");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    out_load |=> st.valid_count == $past(st.valid_count) + {31'd0, $past(res.detected)})
    else $error("event count did not follow detection");

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the slope event detector. Samples go in on the
// stream input. A scoreboard predicts every result from its own copy of the
// thresholds and detector state, and each result transfer is checked field by
// field. The run covers a directed pass over threshold edges, blanking and
// rejection, then random pulse trains under randomised register settings.
// It ends with long hold-off windows and overload settings, with no idling
// on either side.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sed_pkg::*;

  localparam int unsigned STALL_LIMIT      = 2000;
  localparam int unsigned TAIL_CYCLES      = 10;
  localparam int unsigned RANDOM_PHASES    = 8;
  localparam int unsigned PHASE_SAMPLES    = 150;
  localparam int unsigned REPORT_LIMIT     = 100;

  // Threshold edges, overload from idle and while armed, full-scale slopes
  localparam logic [SAMPLE_W-1:0] PULSE_SET [16] = '{
    16'd0, 16'd65535, 16'd0, 16'd32767, 16'd32767, 16'd32867, 16'd32870, 16'd32770,
    16'd32869, 16'd32969, 16'd65535, 16'd0, 16'd100, 16'd200, 16'd32967, 16'd32967
  };
  // Arming slope also inside the fall band, blanking, exact-length accept, reject
  localparam logic [SAMPLE_W-1:0] BLANKING_SET [11] = '{
    16'd32967, 16'd32967, 16'd0, 16'd65535, 16'd65535, 16'd65530,
    16'd1, 16'd1, 16'd1, 16'd31, 16'd31
  };

  // --------------------------------------------------------------------------
  // Scoreboard: detector prediction and the queue of expected results
  // --------------------------------------------------------------------------
  class detector_scoreboard;
    logic [CFG_W-1:0]        interval, min_len, max_len, holdoff;
    logic signed [CFG_W-1:0] rise, overload, fall;
    logic [SAMPLE_W-1:0]     prev_sample;
    logic [TIME_W-1:0]       now, blank_until, length;
    logic [COUNT_W-1:0]      events;
    logic                    armed;
    result_t                 expected_results[$];
    int unsigned             errors, checked;
    int unsigned             n_detected, n_rejected, n_overloaded, n_blanked;

    function new();
      interval     = SAMPLE_INTERVAL_RST;
      min_len      = MIN_LENGTH_RST;
      max_len      = MAX_LENGTH_RST;
      rise         = RISE_LEVEL_RST;
      overload     = OVERLOAD_LEVEL_RST;
      fall         = FALL_LEVEL_RST;
      holdoff      = HOLDOFF_TIME_RST;
      prev_sample  = '0;
      now          = '0;
      blank_until  = '0;
      length       = '0;
      events       = '0;
      armed        = 1'b0;
      errors       = 0;
      checked      = 0;
      n_detected   = 0;
      n_rejected   = 0;
      n_overloaded = 0;
      n_blanked    = 0;
    endfunction

    function void write_register(cfg_index_t idx, logic [CFG_W-1:0] value);
      unique case (idx)
        REG_SAMPLE_INTERVAL: interval = value;
        REG_MIN_LENGTH:      min_len  = value;
        REG_MAX_LENGTH:      max_len  = value;
        REG_RISE_LEVEL:      rise     = value;
        REG_OVERLOAD_LEVEL:  overload = value;
        REG_FALL_LEVEL:      fall     = value;
        REG_HOLDOFF_TIME:    holdoff  = value;
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction

    // back to idle and open the hold-off window
    function void start_blanking();
      armed       = 1'b0;
      length      = '0;
      blank_until = now + holdoff;
    endfunction

    function void predict_sample(logic [SAMPLE_W-1:0] sample);
      result_t want;
      int      diff;
      logic    ending;
      want        = '0;
      diff        = int'(sample) - int'(prev_sample);
      want.slope  = diff[SLOPE_W-1:0];
      prev_sample = sample;
      now         = now + interval;
      ending      = 1'b0;
      // plain unsigned compare: a window whose end wrapped does not blank
      if (now < blank_until) begin
        want.blanked = 1'b1;
        n_blanked++;
      end else if (diff >= int'(overload)) begin
        want.overloaded = 1'b1;
        n_overloaded++;
        start_blanking();
      end else begin
        // the fall test applies only to an event already in progress
        if (!armed) begin
          if (diff >= int'(rise)) armed = 1'b1;
        end else if (diff <= int'(fall)) begin
          ending = 1'b1;
        end
        if (armed) length = length + interval;
        if (ending) begin
          if (length >= min_len && length <= max_len) begin
            events++;
            want.detected = 1'b1;
            n_detected++;
          end else begin
            want.rejected = 1'b1;
            n_rejected++;
          end
          start_blanking();
        end
      end
      want.armed       = armed;
      want.event_total = events;
      expected_results.push_back(want);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("%0t  %s: expected 'h%0h, got 'h%0h", $time, name, want, got);
      end
    endfunction

    function void check_result(logic [OUT_W-1:0] tdata);
      result_t got, want;
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("%0t  unexpected result: expected none, got 'h%0h", $time, tdata);
        return;
      end
      got  = tdata[$bits(result_t)-1:0];
      want = expected_results.pop_front();
      checked++;
      compare_field("slope",       32'(want.slope),      32'(got.slope));
      compare_field("detected",    32'(want.detected),   32'(got.detected));
      compare_field("rejected",    32'(want.rejected),   32'(got.rejected));
      compare_field("overloaded",  32'(want.overloaded), 32'(got.overloaded));
      compare_field("blanked",     32'(want.blanked),    32'(got.blanked));
      compare_field("armed",       32'(want.armed),      32'(got.armed));
      compare_field("event_total", want.event_total,     got.event_total);
      compare_field("padding",     32'd0,                32'(tdata[OUT_W-1:$bits(result_t)]));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block under test
  // --------------------------------------------------------------------------
  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               s_tvalid  = 1'b0;
  logic               s_tready;
  logic [15:0]        s_tdata   = '0;     // [15:0] sample
  logic               m_tvalid;
  logic               m_tready  = 1'b0;
  logic [OUT_W-1:0]   m_tdata;            // [16:0] slope, [17] detected, [18] rejected,
                                          // [19] overloaded, [20] blanked, [21] armed,
                                          // [53:22] event_total, [55:54] zero
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  cfg_index_t         cfg_index = REG_SAMPLE_INTERVAL;
  logic [CFG_W-1:0]   cfg_data  = '0;

  detector_scoreboard sb;
  cfg_t               cur_cfg;
  logic               source_idle = 1'b1;
  logic               sink_idle   = 1'b1;
  logic [4:0]         ready_hold  = '0;
  int unsigned        quiet_cycles = 0;
  int unsigned        n_sent       = 0;
  int unsigned        n_cfg_writes = 0;
  int unsigned        n_settings   = 1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  slope_event_detector i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Result side: random stall bursts while sink idling is enabled
  always @(posedge clk) begin
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1'b1;
    end else if (m_tready && sink_idle && $urandom_range(11) == 0) begin
      m_tready   <= 1'b0;
      ready_hold <= 5'($urandom_range(17));
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Result check on every output transfer
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
  end

  // Watchdog: too long without any transfer ends the run
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("%0t  watchdog: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Helpers
  // --------------------------------------------------------------------------
  function automatic int rand_between(int lo, int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function automatic int clamp(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // mostly a typical value, now and then one of the extremes
  function automatic logic [CFG_W-1:0] pick_value(int lo, int hi, int ext_lo, int ext_hi);
    int v;
    if ($urandom_range(7) == 0) v = $urandom_range(1) ? ext_hi : ext_lo;
    else v = rand_between(lo, hi);
    return v[CFG_W-1:0];
  endfunction

  function automatic cfg_t random_config();
    cfg_t c;
    int   lo;
    c.sample_interval = pick_value(1, 50, 0, 65535);
    c.min_length      = pick_value(0, 150, 0, 65535);
    lo                = int'(c.min_length);
    c.max_length      = pick_value(lo, clamp(lo + 400, 0, 65535), 0, 65535);
    c.rise_level      = pick_value(20, 3000, -32768, 32767);
    c.overload_level  = pick_value(3000, 32767, -32768, 32767);
    c.fall_level      = pick_value(-3000, -20, -32768, 32767);
    c.holdoff_time    = pick_value(0, 120, 0, 65535);
    return c;
  endfunction

  function automatic logic [CFG_W-1:0] field_of(cfg_t c, cfg_index_t idx);
    unique case (idx)
      REG_SAMPLE_INTERVAL: return c.sample_interval;
      REG_MIN_LENGTH:      return c.min_length;
      REG_MAX_LENGTH:      return c.max_length;
      REG_RISE_LEVEL:      return c.rise_level;
      REG_OVERLOAD_LEVEL:  return c.overload_level;
      REG_FALL_LEVEL:      return c.fall_level;
      REG_HOLDOFF_TIME:    return c.holdoff_time;
      default:             return '0;
    endcase
  endfunction

  // One sample transfer, with an occasional gap on the input side
  task automatic send_sample(input logic [SAMPLE_W-1:0] sample);
    if (source_idle && $urandom_range(15) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(18, 1)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= sample;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.predict_sample(sample);
    n_sent++;
  endtask

  // Stop the input stream and wait for every outstanding result
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Write all registers back to back; only called with the block idle
  task automatic set_config(input cfg_t c);
    cfg_index_t idx;
    idx = idx.first();
    cfg_valid <= 1'b1;
    repeat (idx.num()) begin
      cfg_index <= idx;
      cfg_data  <= field_of(c, idx);
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      sb.write_register(idx, field_of(c, idx));
      n_cfg_writes++;
      idx = idx.next();
    end
    cfg_valid <= 1'b0;
    cur_cfg = c;
    n_settings++;
  endtask

  // Pulse: flat baseline, step up near the rise level, noisy plateau, drop
  task automatic send_event();
    int rise_i, fall_i, amp, drop, lvl;
    rise_i = int'($signed(cur_cfg.rise_level));
    fall_i = int'($signed(cur_cfg.fall_level));
    amp    = (rise_i > 0 ? rise_i : 1) + rand_between(-60, 600);
    drop   = (fall_i < 0 ? -fall_i : 1) + rand_between(-60, 600);
    lvl    = rand_between(0, 65535 - clamp(amp, 0, 65535));
    repeat (2) send_sample(16'(lvl));
    lvl = clamp(lvl + amp, 0, 65535);
    send_sample(16'(lvl));
    repeat ($urandom_range(8)) begin
      lvl = clamp(lvl + rand_between(-15, 15), 0, 65535);
      send_sample(16'(lvl));
    end
    send_sample(16'(clamp(lvl - drop, 0, 65535)));
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    cfg_t        c;
    int unsigned target;
    sb      = new();
    cur_cfg = '{SAMPLE_INTERVAL_RST, MIN_LENGTH_RST, MAX_LENGTH_RST, RISE_LEVEL_RST,
                OVERLOAD_LEVEL_RST, FALL_LEVEL_RST, HOLDOFF_TIME_RST};
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: reset thresholds
    foreach (PULSE_SET[i]) send_sample(PULSE_SET[i]);
    drain();

    // directed: rise band below fall band, exact length window, hold-off
    c = '{sample_interval: 16'd7, min_length: 16'd14, max_length: 16'd14,
          rise_level: 16'hFFF6, overload_level: 16'h7FFF, fall_level: 16'd10,
          holdoff_time: 16'd20};
    set_config(c);
    foreach (BLANKING_SET[i]) send_sample(BLANKING_SET[i]);

    // random pulse trains and noise under random settings
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain();
      set_config(random_config());
      source_idle = (p == 0) || ($urandom_range(3) != 0);
      sink_idle   = (p == 0) || ($urandom_range(3) != 0);
      target      = n_sent + PHASE_SAMPLES;
      while (n_sent < target) begin
        if ($urandom_range(3) != 0) send_event();
        else repeat ($urandom_range(4, 1)) send_sample(16'($urandom));
      end
    end

    // most open samples overload, each opening a long hold-off window;
    // no idling on either side from here on
    drain();
    source_idle = 1'b0;
    sink_idle   = 1'b0;
    c = '{sample_interval: 16'd4096, min_length: 16'd0, max_length: 16'hFFFF,
          rise_level: 16'd1, overload_level: 16'h8000, fall_level: 16'hFF9C,
          holdoff_time: 16'hFFFF};
    set_config(c);
    repeat (200) send_sample(16'($urandom));

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.pending() != 0) begin
      $display("%0t  %0d expected results never arrived", $time, sb.pending());
      sb.errors += sb.pending();
    end

    $display("Covered %0d samples under %0d register settings (%0d writes).",
             n_sent, n_settings, n_cfg_writes);
    $display("Checked %0d results: %0d detected, %0d rejected, %0d overloaded, %0d blanked.",
             sb.checked, sb.n_detected, sb.n_rejected, sb.n_overloaded, sb.n_blanked);
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
